### hdl/vfc_pkg.sv
`default_nettype none
package vfc_pkg;

    localparam int unsigned PLANES = 6;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_EXTRACT = 2'd1;
    localparam logic [1:0] CMD_SPHERE  = 2'd2;
    localparam logic [1:0] CMD_BOX     = 2'd3;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         elem_index;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] radius;
    } vfc_in_t;

    typedef struct packed {
        logic visible;
        logic status;
    } vfc_out_t;

    // plane p: column index and subtract flag (right, left, down, up, far, near)
    function automatic logic [1:0] plane_col(input logic [2:0] p);
        logic [1:0] c;
        case (p)
            3'd0, 3'd1: c = 2'd0;
            3'd2, 3'd3: c = 2'd1;
            default:    c = 2'd2;
        endcase
        return c;
    endfunction

    function automatic logic plane_neg(input logic [2:0] p);
        logic n;
        case (p)
            3'd0, 3'd3, 3'd4: n = 1'b1;
            default:          n = 1'b0;
        endcase
        return n;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647)       r = 32'sh7fffffff;
        else if (v < -33'sd2147483648) r = 32'sh80000000;
        else                           r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/view_frustum_culling.sv
`default_nettype none
// Per command: load writes one matrix word; sphere runs 3 MAC steps and a check per
// plane over 6 planes; box runs 3 MAC steps and a check per corner, 8 corners per
// plane; extract per plane runs 4 sums, 3 squares, a root and 4 divides (a degenerate
// plane skips the divides). One word in flight; next input the cycle after the result.
// Synchronous active-low reset clears matrix, planes and the degenerate flag.
module view_frustum_culling
    import vfc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire vfc_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output vfc_out_t      m_data
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SUM   = 4'd1;
    localparam logic [3:0] ST_SQ    = 4'd2;
    localparam logic [3:0] ST_SQRT  = 4'd3;
    localparam logic [3:0] ST_SQW   = 4'd4;
    localparam logic [3:0] ST_DIV   = 4'd5;
    localparam logic [3:0] ST_DIVW  = 4'd6;
    localparam logic [3:0] ST_TMAC  = 4'd7;
    localparam logic [3:0] ST_TCHK  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]  st_reg, st_next;
    logic signed [31:0] mat_reg [16];
    logic signed [31:0] pl_reg  [24];
    logic        degen_reg, degen_next, degacc_reg, degacc_next;
    vfc_in_t     in_reg;
    logic [2:0]  p_reg, p_next;
    logic [1:0]  k_reg, k_next;
    logic [2:0]  c_reg, c_next;
    logic [3:0]  behind_reg, behind_next;
    logic signed [31:0] v_reg [4];
    logic [63:0] acc_reg, acc_next;
    logic [31:0] len_reg;
    logic        vis_reg, vis_next;
    logic        mv_reg, mv_next;

    // shared multiplier operands
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] prod;
    assign prod = 64'(mul_a) * 64'(mul_b);

    logic signed [32:0] sum33;
    logic signed [31:0] ma, mb, vk, cx, cy, cz, coord;
    logic [31:0]  vmag;
    logic         sq_start, dv_start, sq_done, dv_done;
    logic [31:0]  sq_root;
    logic [47:0]  dv_q;
    logic signed [31:0] dq;
    logic         active;
    logic signed [63:0] ev;

    assign ma    = mat_reg[{k_reg, 2'd3}];
    assign mb    = mat_reg[{k_reg, plane_col(p_reg)}];
    assign sum33 = plane_neg(p_reg) ? 33'(ma) - 33'(mb) : 33'(ma) + 33'(mb);
    assign vk    = v_reg[k_reg];
    assign vmag  = vk[31] ? 32'(-33'(vk)) : vk;
    assign cx    = c_reg[0] ? in_reg.b_x : in_reg.a_x;
    assign cy    = c_reg[1] ? in_reg.b_y : in_reg.a_y;
    assign cz    = c_reg[2] ? in_reg.b_z : in_reg.a_z;
    assign coord = (k_reg == 2'd0) ? cx : (k_reg == 2'd1) ? cy : cz;
    assign active = (pl_reg[{p_reg, 2'd0}] != 0) || (pl_reg[{p_reg, 2'd1}] != 0)
                 || (pl_reg[{p_reg, 2'd2}] != 0);
    assign ev = $signed(acc_reg) + ($signed(64'(pl_reg[{p_reg, 2'd3}])) <<< 16);

    always_comb begin
        if (vk[31]) dq = (dv_q > 48'd2147483648) ? 32'sh80000000 : 32'(-49'(dv_q));
        else        dq = (dv_q > 48'd2147483647) ? 32'sh7fffffff : dv_q[31:0];
    end

    always_comb begin
        mul_a = v_reg[k_reg];
        mul_b = v_reg[k_reg];
        if (st_reg == ST_TMAC) begin
            mul_a = (in_reg.cmd == CMD_BOX) ? coord
                  : (k_reg == 2'd0) ? in_reg.a_x : (k_reg == 2'd1) ? in_reg.a_y : in_reg.a_z;
            mul_b = pl_reg[{p_reg, k_reg}];
        end
    end

    vfc_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .start(sq_start), .radicand(acc_reg),
        .done(sq_done), .root(sq_root)
    );
    vfc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start), .mag(vmag), .den(len_reg),
        .done(dv_done), .quot(dv_q)
    );

    always_comb begin
        st_next     = st_reg;
        p_next      = p_reg;
        k_next      = k_reg;
        c_next      = c_reg;
        behind_next = behind_reg;
        acc_next    = acc_reg;
        vis_next    = vis_reg;
        degen_next  = degen_reg;
        degacc_next = degacc_reg;
        mv_next     = mv_reg;
        sq_start    = 1'b0;
        dv_start    = 1'b0;
        case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    p_next = '0; k_next = '0; c_next = '0; behind_next = '0;
                    acc_next = '0; vis_next = 1'b0; degacc_next = 1'b0;
                    case (s_data.cmd)
                        CMD_LOAD:    st_next = ST_OUT;
                        CMD_EXTRACT: st_next = ST_SUM;
                        default: begin
                            st_next  = ST_TMAC;
                            vis_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SUM: begin
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3) begin
                    st_next = ST_SQ;
                    acc_next = '0;
                end
            end
            ST_SQ: begin
                acc_next = acc_reg + prod;
                k_next   = k_reg + 2'd1;
                if (k_reg == 2'd2) begin
                    st_next = ST_SQRT;
                    k_next  = '0;
                end
            end
            ST_SQRT: begin
                sq_start = 1'b1;
                st_next  = ST_SQW;
            end
            ST_SQW: begin
                if (sq_done) begin
                    if (sq_root == 32'd0) begin
                        degacc_next = 1'b1;
                        st_next     = ST_DIVW;
                        k_next      = 2'd3;
                    end else begin
                        st_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                dv_start = 1'b1;
                st_next  = ST_DIVW;
            end
            ST_DIVW: begin
                if (dv_done || len_reg == 32'd0) begin
                    k_next = k_reg + 2'd1;
                    st_next = ST_DIV;
                    if (k_reg == 2'd3) begin
                        k_next = '0;
                        p_next = p_reg + 3'd1;
                        st_next = ST_SUM;
                        if (p_reg == 3'(PLANES - 1)) begin
                            st_next    = ST_OUT;
                            degen_next = degacc_reg;
                        end
                    end
                end
            end
            ST_TMAC: begin
                acc_next = acc_reg + prod;
                k_next   = k_reg + 2'd1;
                if (k_reg == 2'd2) begin
                    k_next  = '0;
                    st_next = ST_TCHK;
                end
            end
            ST_TCHK: begin
                acc_next = '0;
                st_next  = ST_TMAC;
                if (in_reg.cmd == CMD_SPHERE) begin
                    if (active && (ev + ($signed(64'(in_reg.radius)) <<< 16)) <= 0)
                        vis_next = 1'b0;
                    p_next = p_reg + 3'd1;
                    if (p_reg == 3'(PLANES - 1)) st_next = ST_OUT;
                end else begin
                    behind_next = behind_reg + ((ev < 0) ? 4'd1 : 4'd0);
                    c_next = c_reg + 3'd1;
                    if (c_reg == 3'd7) begin
                        if (active && behind_next == 4'd8) vis_next = 1'b0;
                        behind_next = '0;
                        p_next = p_reg + 3'd1;
                        if (p_reg == 3'(PLANES - 1)) st_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                mv_next = 1'b1;
                if (mv_reg && m_ready) begin
                    mv_next = 1'b0;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            mv_reg    <= 1'b0;
            degen_reg <= 1'b0;
            for (int i = 0; i < 16; i++) mat_reg[i] <= '0;
            for (int i = 0; i < 24; i++) pl_reg[i] <= '0;
        end else begin
            st_reg    <= st_next;
            mv_reg    <= mv_next;
            degen_reg <= degen_next;
            if (st_reg == ST_IDLE && s_valid && s_data.cmd == CMD_LOAD)
                mat_reg[s_data.elem_index] <= s_data.a_x;
            if (st_reg == ST_SQW && sq_done && sq_root == 32'd0) begin
                for (int i = 0; i < 4; i++) pl_reg[{p_reg, 2'(i)}] <= '0;
            end
            if (st_reg == ST_DIVW && dv_done && len_reg != 32'd0)
                pl_reg[{p_reg, k_reg}] <= dq;
        end
        p_reg      <= p_next;
        k_reg      <= k_next;
        c_reg      <= c_next;
        behind_reg <= behind_next;
        acc_reg    <= acc_next;
        vis_reg    <= vis_next;
        degacc_reg <= degacc_next;
        if (st_reg == ST_IDLE && s_valid) in_reg <= s_data;
        if (st_reg == ST_SUM) v_reg[k_reg] <= sat32(sum33);
        if (st_reg == ST_SQW && sq_done) len_reg <= sq_root;
    end

    assign s_ready        = (st_reg == ST_IDLE);
    assign m_valid        = mv_reg;
    assign m_data.visible = vis_reg;
    assign m_data.status  = degen_reg;

    a_out_only_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> st_reg == ST_OUT) else $error("result outside output state");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready while result pending");
    a_vis_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (in_reg.cmd == CMD_LOAD || in_reg.cmd == CMD_EXTRACT)) |-> !m_data.visible)
        else $error("visible set for load or extract");
endmodule
`default_nettype wire

### hdl/vfc_sqrt.sv
`default_nettype none
module vfc_sqrt
    import vfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] radicand,
    output logic             done,
    output logic [31:0]      root
);
    // digit-by-digit root, one result bit per cycle, 32-bit result
    logic [63:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic [63:0] src_reg, src_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [65:0] cur;
    logic [65:0] trial;

    assign cur   = {rem_reg, src_reg[63:62]};
    assign trial = {32'd0, res_reg, 2'b01};

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        src_next  = src_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            res_next  = '0;
            src_next  = radicand;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            src_next = {src_reg[61:0], 2'b00};
            if (cur >= trial) begin
                rem_next = cur[63:0] - trial[63:0];
                res_next = {res_reg[30:0], 1'b1};
            end else begin
                rem_next = cur[63:0];
                res_next = {res_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        res_reg <= res_next;
        src_reg <= src_next;
    end

    assign done = done_reg;
    assign root = res_reg;
endmodule
`default_nettype wire

### hdl/vfc_div.sv
`default_nettype none
module vfc_div
    import vfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [31:0] mag,
    input  wire logic [31:0] den,
    output logic             done,
    output logic [47:0]      quot
);
    // restoring divider: floor((mag << 16) / den), one quotient bit per cycle, 48-bit quotient
    logic [47:0] num_reg, num_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] den_reg, den_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] sh;

    assign sh = {rem_reg[31:0], num_reg[47]};

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            num_next  = {mag, 16'd0};
            rem_next  = '0;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, den_reg}) begin
                rem_next = sh - {1'b0, den_reg};
                num_next = {num_reg[46:0], 1'b1};
            end else begin
                rem_next = sh;
                num_next = {num_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;
endmodule
`default_nettype wire
